### src/crcb_pkg.sv
`default_nettype none

package crcb_pkg;

   // record layout and crc constants
   localparam int          CHANNELS_DEFAULT = 4;
   localparam int          QUEUE_DEPTH      = 2;
   localparam logic [31:0] CRC_POLY         = 32'hEDB88320;
   localparam logic [31:0] CRC_INIT         = 32'hFFFFFFFF;
   localparam logic [31:0] MAGIC_RESET      = 32'h47435A50;
   localparam logic [31:0] VERSION_RESET    = 32'd1;
   localparam logic [30:0] MAX_ZERO_RESET   = 31'd3000000;

   // register indexes on the csr port
   localparam logic [1:0] CSR_MAGIC    = 2'd0;
   localparam logic [1:0] CSR_VERSION  = 2'd1;
   localparam logic [1:0] CSR_MAX_ZERO = 2'd2;

   typedef enum logic {
      MODE_CHECK = 1'b0,
      MODE_BUILD = 1'b1
   } record_mode_type;

   // which word the back end emits in build mode
   typedef enum logic [1:0] {
      STEP_MAGIC   = 2'd0,
      STEP_VERSION = 2'd1,
      STEP_VALUE   = 2'd2,
      STEP_CRC     = 2'd3
   } step_type;

   typedef struct packed {
      logic        kind;
      logic [31:0] word;
   } req_type;

   typedef struct packed {
      logic [31:0] out_word;
      logic        is_verdict;
      logic        valid_res;
      logic        out_last;
   } rsp_type;

   // classified word handed from front to back
   typedef struct packed {
      record_mode_type mode;
      logic            first;
      logic            last;
      logic            crc_word;
      logic            bad;
      logic [31:0]     word;
   } op_type;

   typedef logic [31:0][31:0] crc_cols_type;

   // crc of a single set bit after one full word update, one column per bit
   function automatic crc_cols_type crc_columns();
      crc_cols_type cols;
      logic [31:0]  v;
      for (int i = 0; i < 32; i++) begin
         v = 32'd1 << i;
         for (int j = 0; j < 32; j++) begin
            v = v[0] ? ((v >> 1) ^ CRC_POLY) : (v >> 1);
         end
         cols[i] = v;
      end
      return cols;
   endfunction

endpackage

`default_nettype wire

### src/crcb_fifo.sv
`default_nettype none

module crcb_fifo #(
   parameter int  DEPTH     = crcb_pkg::QUEUE_DEPTH,
   parameter type data_type = logic
) (
   input  wire      clock,
   input  wire      reset,
   input  wire      push,
   input  data_type data_in,
   output logic     full,
   input  wire      pop,
   output data_type data_out,
   output logic     empty
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   data_type        mem_ff [0:DEPTH-1];
   logic [AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;
   logic            do_push, do_pop;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign data_out = mem_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= data_in;
      end
   end

endmodule

`default_nettype wire

### src/crcb_front.sv
`default_nettype none

module crcb_front #(
   parameter int CHANNELS = crcb_pkg::CHANNELS_DEFAULT
) (
   input  wire              clock,
   input  wire              reset,
   input  wire              req_push,
   input  crcb_pkg::req_type req_data,
   input  wire              op_full,
   output logic             op_push,
   output crcb_pkg::op_type op_data,
   input  wire [31:0]       record_magic,
   input  wire [31:0]       record_version,
   input  wire [30:0]       max_zero
);

   localparam int PW = $clog2(CHANNELS + 3);

   logic [PW-1:0]             pos_ff, pos_in;
   crcb_pkg::record_mode_type mode_ff, mode_in;
   logic                      first;
   logic                      range_bad;

   assign op_push   = req_push && !op_full;
   assign first     = (pos_ff == '0);
   assign range_bad = req_data.word[31] || (req_data.word[30:0] > max_zero);

   // classify the request by its place in the record
   always_comb begin
      mode_in = first ? crcb_pkg::record_mode_type'(req_data.kind) : mode_ff;
      pos_in  = pos_ff;
      op_data          = '0;
      op_data.mode     = mode_in;
      op_data.first    = first;
      op_data.word     = req_data.word;
      if (mode_in == crcb_pkg::MODE_CHECK) begin
         if (pos_ff < PW'(CHANNELS + 2)) begin
            if (first) begin
               op_data.bad = (req_data.word != record_magic);
            end else if (pos_ff == PW'(1)) begin
               op_data.bad = (req_data.word != record_version);
            end else begin
               op_data.bad = range_bad;
            end
            pos_in = pos_ff + 1'b1;
         end else begin
            op_data.crc_word = 1'b1;
            op_data.last     = 1'b1;
            pos_in           = '0;
         end
      end else begin
         if (pos_ff == PW'(CHANNELS - 1)) begin
            op_data.last = 1'b1;
            pos_in       = '0;
         end else begin
            pos_in = pos_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         mode_ff <= crcb_pkg::MODE_CHECK;
      end else if (op_push) begin
         pos_ff  <= pos_in;
         mode_ff <= mode_in;
      end
   end

endmodule

`default_nettype wire

### src/crcb_back.sv
`default_nettype none

module crcb_back (
   input  wire               clock,
   input  wire               reset,
   input  wire               op_valid,
   input  crcb_pkg::op_type  op_data,
   output logic              op_pop,
   input  wire               out_room,
   output logic              out_push,
   output crcb_pkg::rsp_type out_data,
   input  wire [31:0]        record_magic,
   input  wire [31:0]        record_version
);

   localparam crcb_pkg::crc_cols_type CRC_COLS = crcb_pkg::crc_columns();

   logic [31:0]        crc_ff, crc_in;
   logic               ok_ff, ok_in;
   logic [1:0]         sub_ff, sub_in;
   crcb_pkg::step_type step;
   logic [31:0]        crc_src;
   logic [31:0]        crc_x;
   logic [31:0]        crc_next;
   logic               emit, done, update, restart, fire;

   // build steps: magic and version only ahead of a record's first value
   assign step = crcb_pkg::step_type'(op_data.first ? sub_ff : sub_ff + 2'd2);

   always_comb begin
      case (step)
         crcb_pkg::STEP_MAGIC:   crc_src = record_magic;
         crcb_pkg::STEP_VERSION: crc_src = record_version;
         default:                crc_src = op_data.word;
      endcase
   end

   // one full 32-bit crc update as an xor of columns
   assign crc_x = crc_ff ^ (op_data.mode == crcb_pkg::MODE_CHECK ? op_data.word : crc_src);

   always_comb begin
      crc_next = '0;
      for (int i = 0; i < 32; i++) begin
         if (crc_x[i]) begin
            crc_next = crc_next ^ CRC_COLS[i];
         end
      end
   end

   // step decode
   always_comb begin
      emit     = 1'b0;
      done     = 1'b1;
      update   = 1'b0;
      restart  = 1'b0;
      ok_in    = ok_ff;
      out_data = '0;
      if (op_data.mode == crcb_pkg::MODE_CHECK) begin
         if (op_data.crc_word) begin
            emit                = 1'b1;
            restart             = 1'b1;
            out_data.is_verdict = 1'b1;
            out_data.valid_res  = ok_ff && (~crc_ff == op_data.word);
            out_data.out_last   = 1'b1;
         end else begin
            update = 1'b1;
            ok_in  = ok_ff && !op_data.bad;
         end
      end else begin
         emit = 1'b1;
         case (step)
            crcb_pkg::STEP_MAGIC,
            crcb_pkg::STEP_VERSION: begin
               update            = 1'b1;
               done              = 1'b0;
               out_data.out_word = crc_src;
            end
            crcb_pkg::STEP_VALUE: begin
               update            = 1'b1;
               done              = !op_data.last;
               out_data.out_word = crc_src;
            end
            default: begin
               restart           = 1'b1;
               out_data.out_word = ~crc_ff;
               out_data.out_last = 1'b1;
            end
         endcase
      end
   end

   assign fire     = op_valid && (!emit || out_room);
   assign op_pop   = fire && done;
   assign out_push = fire && emit;

   // running state
   always_comb begin
      sub_in = done ? 2'd0 : sub_ff + 2'd1;
      if (restart) begin
         crc_in = crcb_pkg::CRC_INIT;
      end else if (update) begin
         crc_in = crc_next;
      end else begin
         crc_in = crc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff <= crcb_pkg::CRC_INIT;
         ok_ff  <= 1'b1;
         sub_ff <= '0;
      end else if (fire) begin
         crc_ff <= crc_in;
         ok_ff  <= restart ? 1'b1 : ok_in;
         sub_ff <= sub_in;
      end
   end

endmodule

`default_nettype wire

### src/calib_record_crc_check_build.sv
// Calibration record CRC checker and builder.
// Requests enter on a queue-style port: req_data is taken at a clock edge
// with req_push high and req_full low. kind is read at the first request of
// a record: 0 checks a stored record (magic, version, CHANNELS values, CRC),
// 1 builds one from CHANNELS values. Results leave on rsp_data while rsp_empty
// is low and are taken with rsp_pop. A check gives one verdict on the CRC
// word; a build gives magic, version, each value and the CRC word.
// Registers are written on the csr port (csr_we, csr_index, csr_wdata); the
// user must do so only while the block is idle, the block does not enforce it.
// A request is held in the work queue, then its result in the result queue.
// Throughput: one request per cycle while req_full is low; the back end
// makes a single output write and one 32-bit CRC update per cycle while
// the result queue has room, and a build record gives CHANNELS + 3 words.
// When rsp_pop stays low the result queue fills, then the work queue, and
// req_full rises; nothing is dropped. Reset (synchronous) empties both
// queues, restarts the record and restores register reset values.
`default_nettype none

module calib_record_crc_check_build #(
   parameter int CHANNELS = crcb_pkg::CHANNELS_DEFAULT
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_push,
   input  crcb_pkg::req_type req_data,
   output logic              req_full,
   output crcb_pkg::rsp_type rsp_data,
   output logic              rsp_empty,
   input  wire               rsp_pop,
   input  wire               csr_we,
   input  wire [1:0]         csr_index,
   input  wire [31:0]        csr_wdata
);

   logic [31:0]       magic_ff;
   logic [31:0]       version_ff;
   logic [30:0]       max_zero_ff;
   logic              op_push, op_pop, op_full, op_empty;
   crcb_pkg::op_type  op_wr, op_rd;
   logic              out_push, out_full;
   crcb_pkg::rsp_type out_wr;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         magic_ff    <= crcb_pkg::MAGIC_RESET;
         version_ff  <= crcb_pkg::VERSION_RESET;
         max_zero_ff <= crcb_pkg::MAX_ZERO_RESET;
      end else if (csr_we) begin
         case (csr_index)
            crcb_pkg::CSR_MAGIC:    magic_ff    <= csr_wdata;
            crcb_pkg::CSR_VERSION:  version_ff  <= csr_wdata;
            crcb_pkg::CSR_MAX_ZERO: max_zero_ff <= csr_wdata[30:0];
            default: ;
         endcase
      end
   end

   assign req_full = op_full;

   // front: record position, mode and word checks
   crcb_front #(
      .CHANNELS(CHANNELS)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_data      (req_data),
      .op_full       (op_full),
      .op_push       (op_push),
      .op_data       (op_wr),
      .record_magic  (magic_ff),
      .record_version(version_ff),
      .max_zero      (max_zero_ff)
   );

   // work queue between front and back
   crcb_fifo #(
      .DEPTH    (crcb_pkg::QUEUE_DEPTH),
      .data_type(crcb_pkg::op_type)
   ) u_op_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (op_push),
      .data_in (op_wr),
      .full    (op_full),
      .pop     (op_pop),
      .data_out(op_rd),
      .empty   (op_empty)
   );

   // back: crc update and result generation
   crcb_back u_back (
      .clock         (clock),
      .reset         (reset),
      .op_valid      (!op_empty),
      .op_data       (op_rd),
      .op_pop        (op_pop),
      .out_room      (!out_full),
      .out_push      (out_push),
      .out_data      (out_wr),
      .record_magic  (magic_ff),
      .record_version(version_ff)
   );

   // result queue
   crcb_fifo #(
      .DEPTH    (crcb_pkg::QUEUE_DEPTH),
      .data_type(crcb_pkg::rsp_type)
   ) u_rsp_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (out_push),
      .data_in (out_wr),
      .full    (out_full),
      .pop     (rsp_pop),
      .data_out(rsp_data),
      .empty   (rsp_empty)
   );

endmodule

`default_nettype wire

### tb/sv/testbench.sv
`timescale 1ns / 100ps

module testbench;

   localparam int         CH            = crcb_pkg::CHANNELS_DEFAULT;
   localparam int         CHECK_LEN     = CH + 3;
   localparam int         STALL_LIMIT   = 2000;
   localparam int         SETTLE_CYCLES = 8;
   // index with no register behind it, writes there must change nothing
   localparam logic [1:0] CSR_SPARE     = 2'd3;

   typedef enum int {
      FLAW_NONE,
      FLAW_BIT,
      FLAW_RANGE,
      FLAW_SIGN,
      FLAW_MAGIC,
      FLAW_VERSION,
      FLAW_NOISE
   } flaw_type;

   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_push  = 1'b0;
   crcb_pkg::req_type req_data  = '0;
   logic              req_full;
   crcb_pkg::rsp_type rsp_data;
   logic              rsp_empty;
   logic              rsp_pop   = 1'b0;
   logic              csr_we    = 1'b0;
   logic [1:0]        csr_index = crcb_pkg::CSR_MAGIC;
   logic [31:0]       csr_wdata = '0;

   // predicted register and record state
   logic [31:0]               cfg_magic    = crcb_pkg::MAGIC_RESET;
   logic [31:0]               cfg_version  = crcb_pkg::VERSION_RESET;
   logic [30:0]               cfg_max_zero = crcb_pkg::MAX_ZERO_RESET;
   logic [31:0]               rec_crc      = crcb_pkg::CRC_INIT;
   logic [4:0]                rec_pos      = '0;
   crcb_pkg::record_mode_type rec_mode     = crcb_pkg::MODE_CHECK;
   logic                      rec_ok       = 1'b1;

   crcb_pkg::rsp_type results_due [$];
   logic [31:0]       rec_words [0:CHECK_LEN-1];

   int send_idle_pct = 14;
   int recv_idle_pct = 73;
   int hold_left     = 0;
   int fault_count   = 0;
   int quiet_cycles  = 0;

   calib_record_crc_check_build #(
      .CHANNELS(CH)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_data (req_data),
      .req_full (req_full),
      .rsp_data (rsp_data),
      .rsp_empty(rsp_empty),
      .rsp_pop  (rsp_pop),
      .csr_we   (csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   // reflected crc-32, one word low byte first
   function automatic logic [31:0] crc32_word(logic [31:0] crc, logic [31:0] w);
      logic [31:0] c;
      c = crc ^ w;
      for (int i = 0; i < 32; i++) begin
         c = c[0] ? ((c >> 1) ^ crcb_pkg::CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

   function automatic void report_fault(string what);
      if (fault_count < 10) $display("%0t: %s", $time, what);
      fault_count++;
   endfunction

   function automatic void push_result(logic [31:0] w, logic verdict, logic ok, logic last);
      crcb_pkg::rsp_type r;
      r.out_word   = w;
      r.is_verdict = verdict;
      r.valid_res  = ok;
      r.out_last   = last;
      results_due.push_back(r);
   endfunction

   function automatic void restart_record();
      rec_crc = crcb_pkg::CRC_INIT;
      rec_pos = '0;
      rec_ok  = 1'b1;
   endfunction

   // expected results of one accepted request
   function automatic void advance_record(logic kind, logic [31:0] w);
      if (rec_pos == 0) rec_mode = crcb_pkg::record_mode_type'(kind);
      if (rec_mode == crcb_pkg::MODE_CHECK) begin
         if (rec_pos < CH + 2) begin
            if (rec_pos == 0) begin
               if (w != cfg_magic) rec_ok = 1'b0;
            end else if (rec_pos == 1) begin
               if (w != cfg_version) rec_ok = 1'b0;
            end else if (w[31] || w > {1'b0, cfg_max_zero}) begin
               rec_ok = 1'b0;
            end
            rec_crc = crc32_word(rec_crc, w);
            rec_pos = rec_pos + 5'd1;
         end else begin
            push_result(32'd0, 1'b1, rec_ok && (~rec_crc == w), 1'b1);
            restart_record();
         end
      end else begin
         if (rec_pos == 0) begin
            rec_crc = crc32_word(rec_crc, cfg_magic);
            rec_crc = crc32_word(rec_crc, cfg_version);
            push_result(cfg_magic, 1'b0, 1'b0, 1'b0);
            push_result(cfg_version, 1'b0, 1'b0, 1'b0);
         end
         rec_crc = crc32_word(rec_crc, w);
         push_result(w, 1'b0, 1'b0, 1'b0);
         rec_pos = rec_pos + 5'd1;
         if (rec_pos >= CH) begin
            push_result(~rec_crc, 1'b0, 1'b0, 1'b1);
            restart_record();
         end
      end
   endfunction

   function automatic void check_result(crcb_pkg::rsp_type got);
      crcb_pkg::rsp_type exp;
      if (results_due.size() == 0) begin
         report_fault($sformatf("unexpected result word %h verdict %b valid %b last %b",
                                got.out_word, got.is_verdict, got.valid_res, got.out_last));
         return;
      end
      exp = results_due.pop_front();
      if (got.out_word !== exp.out_word || got.is_verdict !== exp.is_verdict ||
          got.valid_res !== exp.valid_res || got.out_last !== exp.out_last) begin
         report_fault($sformatf({"mismatch: expected word %h verdict %b valid %b last %b,",
                                 " got word %h verdict %b valid %b last %b"},
                                exp.out_word, exp.is_verdict, exp.valid_res, exp.out_last,
                                got.out_word, got.is_verdict, got.valid_res, got.out_last));
      end
   endfunction

   // result side: check what was taken, then decide the next pop
   always @(posedge clock) begin
      if (!reset && rsp_pop && rsp_empty === 1'b0) check_result(rsp_data);
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_pop <= 1'b0;
      end else begin
         rsp_pop <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // watchdog on cycles with no transfer on either side
   always @(posedge clock) begin
      if (reset || (req_push && req_full === 1'b0) || (rsp_pop && rsp_empty === 1'b0))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // offer one request, with a random gap ahead of it
   task automatic send_request(input logic kind, input logic [31:0] w);
      int                gap;
      crcb_pkg::req_type r;
      gap = 0;
      while ($urandom_range(0, 99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      r.kind = kind;
      r.word = w;
      req_push <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (req_full !== 1'b0) @(posedge clock);
      advance_record(kind, w);
   endtask

   // sender pauses until every predicted result has been taken
   task automatic wait_drained();
      req_push <= 1'b0;
      while (results_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [1:0] idx, input logic [31:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         crcb_pkg::CSR_MAGIC:    cfg_magic    = data;
         crcb_pkg::CSR_VERSION:  cfg_version  = data;
         crcb_pkg::CSR_MAX_ZERO: cfg_max_zero = data[30:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   // kind matters only on the first word, the rest carry random kinds
   task automatic send_staged(input int n, input logic first_kind);
      for (int i = 0; i < n; i++) begin
         send_request(i == 0 ? first_kind : ($urandom_range(0, 1) != 0), rec_words[i]);
      end
   endtask

   function automatic void seal_check_record();
      logic [31:0] c;
      c = crcb_pkg::CRC_INIT;
      for (int i = 0; i < CH + 2; i++) c = crc32_word(c, rec_words[i]);
      rec_words[CH + 2] = ~c;
   endfunction

   function automatic logic [31:0] zero_in_range();
      case ($urandom_range(0, 3))
         0:       return 32'd0;
         1:       return {1'b0, cfg_max_zero};
         default: return $urandom_range(0, {1'b0, cfg_max_zero});
      endcase
   endfunction

   // stored record under the current settings, with an optional defect
   function automatic void stage_random_check(flaw_type flaw);
      int pick;
      int bit_at;
      rec_words[0] = cfg_magic;
      rec_words[1] = cfg_version;
      for (int i = 2; i < CH + 2; i++) rec_words[i] = zero_in_range();
      pick = $urandom_range(2, CH + 1);
      case (flaw)
         FLAW_RANGE:   rec_words[pick] = {1'b0, cfg_max_zero} + 32'd1 + $urandom_range(0, 1000);
         FLAW_SIGN:    rec_words[pick][31] = 1'b1;
         FLAW_MAGIC:   rec_words[0] = rec_words[0] ^ ($urandom() | 32'd1);
         FLAW_VERSION: rec_words[1] = $urandom();
         FLAW_NOISE: begin
            for (int i = 0; i < CH + 2; i++) rec_words[i] = $urandom();
         end
         default: ;
      endcase
      seal_check_record();
      if (flaw == FLAW_BIT) begin
         pick   = $urandom_range(0, CH + 2);
         bit_at = $urandom_range(0, 31);
         rec_words[pick][bit_at] = ~rec_words[pick][bit_at];
      end
      if (flaw == FLAW_NOISE) rec_words[CH + 2] = $urandom();
   endfunction

   task automatic run_random_records(input int count);
      int       roll;
      flaw_type flaw;
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 99) < 45) begin
            for (int i = 0; i < CH; i++) begin
               rec_words[i] = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom();
            end
            send_staged(CH, crcb_pkg::MODE_BUILD);
         end else begin
            roll = $urandom_range(0, 99);
            if (roll < 50)      flaw = FLAW_NONE;
            else if (roll < 60) flaw = FLAW_BIT;
            else if (roll < 70) flaw = FLAW_RANGE;
            else if (roll < 78) flaw = FLAW_SIGN;
            else if (roll < 86) flaw = FLAW_MAGIC;
            else if (roll < 92) flaw = FLAW_VERSION;
            else                flaw = FLAW_NOISE;
            stage_random_check(flaw);
            send_staged(CHECK_LEN, crcb_pkg::MODE_CHECK);
         end
      end
   endtask

   // extremes under reset settings: build, good check, range and crc failures
   task automatic test_directed_records();
      logic [31:0] extreme_vals [0:3];
      send_idle_pct = 14;
      recv_idle_pct = 73;
      extreme_vals = '{32'd0, 32'hFFFFFFFF, 32'h80000000, 32'h7FFFFFFF};
      for (int i = 0; i < CH; i++) rec_words[i] = extreme_vals[i % 4];
      send_staged(CH, crcb_pkg::MODE_BUILD);

      // values at both ends of the valid range
      extreme_vals = '{32'd0, {1'b0, cfg_max_zero}, 32'd1, {1'b0, cfg_max_zero} - 32'd1};
      rec_words[0] = cfg_magic;
      rec_words[1] = cfg_version;
      for (int i = 0; i < CH; i++) rec_words[i + 2] = extreme_vals[i % 4];
      seal_check_record();
      send_staged(CHECK_LEN, crcb_pkg::MODE_CHECK);

      // just over the limit and negative values, crc still right
      extreme_vals = '{{1'b0, cfg_max_zero} + 32'd1, 32'h80000000, 32'hFFFFFFFF, 32'd0};
      for (int i = 0; i < CH; i++) rec_words[i + 2] = extreme_vals[i % 4];
      seal_check_record();
      send_staged(CHECK_LEN, crcb_pkg::MODE_CHECK);

      // good content, crc off by one bit
      for (int i = 0; i < CH; i++) rec_words[i + 2] = 32'd5 + i;
      seal_check_record();
      rec_words[CH + 2] = rec_words[CH + 2] ^ 32'd1;
      send_staged(CHECK_LEN, crcb_pkg::MODE_CHECK);
      wait_drained();
   endtask

   task automatic test_low_settings();
      send_idle_pct = 14;
      recv_idle_pct = 73;
      write_register(crcb_pkg::CSR_MAGIC, 32'd0);
      write_register(crcb_pkg::CSR_VERSION, 32'd0);
      // top bit is dropped, so this leaves zero as the only valid value
      write_register(crcb_pkg::CSR_MAX_ZERO, 32'h80000000);
      write_register(CSR_SPARE, $urandom());
      run_random_records(24);
      wait_drained();
   endtask

   task automatic test_high_settings();
      send_idle_pct = 73;
      recv_idle_pct = 14;
      write_register(crcb_pkg::CSR_MAGIC, 32'hFFFFFFFF);
      write_register(crcb_pkg::CSR_VERSION, 32'hFFFFFFFF);
      write_register(crcb_pkg::CSR_MAX_ZERO, 32'h7FFFFFFF);
      run_random_records(24);
      wait_drained();
   endtask

   // receiver stalls long while builds keep coming, so the input backs up
   task automatic test_full_backpressure();
      send_idle_pct = 0;
      hold_left     = 80;
      for (int n = 0; n < 3; n++) begin
         for (int i = 0; i < CH; i++) rec_words[i] = $urandom();
         send_staged(CH, crcb_pkg::MODE_BUILD);
      end
      stage_random_check(FLAW_NONE);
      send_staged(CHECK_LEN, crcb_pkg::MODE_CHECK);
      wait_drained();
      send_idle_pct = 73;
   endtask

   task automatic test_random_settings();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      for (int round = 0; round < 2; round++) begin
         write_register(crcb_pkg::CSR_MAGIC, $urandom());
         write_register(crcb_pkg::CSR_VERSION, $urandom());
         write_register(crcb_pkg::CSR_MAX_ZERO, $urandom());
         run_random_records(10);
         wait_drained();
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_records();
      test_low_settings();
      test_high_settings();
      test_full_backpressure();
      test_random_settings();
      wait_drained();
      if (results_due.size() != 0)
         report_fault($sformatf("%0d results never arrived", results_due.size()));
      if (fault_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
